[hw/rtl/dbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA burst legalizer package
// Field widths, codes and item types shared by the legalizer modules.
// ----------------------------------------------------------------------------
package dbl_pkg;

  localparam int WIDTH_BYTES_DEF = 8;
  localparam int RES_DEPTH_DEF   = 4;

  localparam int ADDR_W     = 64;
  localparam int LEN_W      = 32;
  localparam int BYTES_W    = 13;
  localparam int LG_W       = 4;
  localparam int LANE_W     = 3;
  localparam int BEATS_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Boundary exponents above this value are clamped to it.
  localparam logic [LG_W-1:0] MAX_BND_LOG2 = 4'd12;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_ZERO_LEN = 2'd2,
    KIND_BUSY     = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RD_BND_LOG2 = 2'd0,
    REG_WR_BND_LOG2 = 2'd1,
    REG_RD_BURSTS   = 2'd2,
    REG_WR_BURSTS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [LEN_W-1:0]  byte_count;
    logic              indep_rw;
    logic              final_of_job;
    logic              indep_aw;
    logic              read_ready;
    logic              write_ready;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  split_addr;
    logic [BYTES_W-1:0] split_bytes;
    logic [LANE_W-1:0]  first_offset;
    logic [LANE_W-1:0]  tail_bytes;
    logic [LANE_W-1:0]  lane_shift;
    logic [BEATS_W-1:0] beat_count;
    logic               last_split;
    logic               job_last;
    logic               aw_decoupled;
    logic               run_end;
  } out_item_t;

endpackage

[hw/rtl/dbl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA burst legalizer channels
// Valid/ready channels for request items and split result items.
// ----------------------------------------------------------------------------
interface dbl_in_if;
  logic             valid;
  logic             ready;
  dbl_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface dbl_out_if;
  logic              valid;
  logic              ready;
  dbl_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[hw/rtl/dbl_side_len.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Side burst length
// Bytes one side may move next: the distance to its boundary, capped by the
// bytes left. Zero when the side is not active.
// ----------------------------------------------------------------------------
module dbl_side_len #(
  parameter int WIDTH_BYTES = dbl_pkg::WIDTH_BYTES_DEF
) (
  input  logic                         active,
  input  logic [dbl_pkg::ADDR_W-1:0]   next_addr,
  input  logic [dbl_pkg::LEN_W-1:0]    left,
  input  logic [dbl_pkg::LG_W-1:0]     bnd_log2,
  input  logic                         bursts,
  output logic [dbl_pkg::BYTES_W-1:0]  avail
);

  localparam logic [6:0] WIDTH_V = 7'(WIDTH_BYTES);
  localparam logic [6:0] WMASK_V = 7'(WIDTH_BYTES - 1);

  logic [dbl_pkg::LG_W-1:0]    lg;
  logic [dbl_pkg::BYTES_W-1:0] bnd;
  logic [dbl_pkg::BYTES_W-1:0] bnd_gap;
  logic [6:0]                  word_gap;

  always_comb begin
    lg       = (bnd_log2 > dbl_pkg::MAX_BND_LOG2) ? dbl_pkg::MAX_BND_LOG2 : bnd_log2;
    bnd      = dbl_pkg::BYTES_W'(1) << lg;
    word_gap = WIDTH_V - (next_addr[6:0] & WMASK_V);
    if (bursts) begin
      bnd_gap = bnd - (next_addr[dbl_pkg::BYTES_W-1:0] & (bnd - dbl_pkg::BYTES_W'(1)));
    end else begin
      bnd_gap = dbl_pkg::BYTES_W'(word_gap);
    end
    if (!active) begin
      avail = '0;
    end else if (left < dbl_pkg::LEN_W'(bnd_gap)) begin
      avail = left[dbl_pkg::BYTES_W-1:0];
    end else begin
      avail = bnd_gap;
    end
  end

endmodule

[hw/rtl/dbl_split_fmt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split formatter
// Builds one split result item from a burst's address, size and side state.
// ----------------------------------------------------------------------------
module dbl_split_fmt #(
  parameter int WIDTH_BYTES = dbl_pkg::WIDTH_BYTES_DEF
) (
  input  dbl_pkg::kind_t               kind,
  input  logic [dbl_pkg::ADDR_W-1:0]   addr,
  input  logic [dbl_pkg::BYTES_W-1:0]  bytes,
  input  logic [dbl_pkg::LEN_W-1:0]    left,
  input  logic [dbl_pkg::LANE_W-1:0]   shift,
  input  logic [1:0]                   flags,
  output dbl_pkg::out_item_t           item
);

  localparam logic [6:0] WMASK_V = 7'(WIDTH_BYTES - 1);
  localparam int         WLOG2   = $clog2(WIDTH_BYTES);

  logic [6:0]  off;
  logic [13:0] span;
  logic [6:0]  tail;
  logic [13:0] beats;
  logic        last;

  always_comb begin
    off   = addr[6:0] & WMASK_V;
    span  = 14'(bytes) + 14'(off);
    tail  = span[6:0] & WMASK_V;
    beats = ((span - 14'd1) >> WLOG2) + 14'd1;
    last  = (dbl_pkg::LEN_W'(bytes) == left);

    item              = '0;
    item.kind         = kind;
    item.split_addr   = addr;
    item.split_bytes  = bytes;
    item.first_offset = off[dbl_pkg::LANE_W-1:0];
    item.tail_bytes   = tail[dbl_pkg::LANE_W-1:0];
    item.lane_shift   = shift;
    item.beat_count   = beats[dbl_pkg::BEATS_W-1:0];
    item.last_split   = last;
    item.job_last     = last & flags[0];
    item.aw_decoupled = flags[1];
  end

endmodule

[hw/rtl/dbl_result_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two result items per cycle and
// presents one item per cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module dbl_result_fifo #(
  parameter int DEPTH = dbl_pkg::RES_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_cnt,
  input  dbl_pkg::out_item_t push_data [2],
  output logic               room2,
  dbl_out_if.source          out_ch
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dbl_pkg::out_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   wr_ptr_1;
  logic               pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    if (p == PTR_W'(DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + PTR_W'(1);
    end
    return q;
  endfunction

  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (cnt_r != '0);
  assign out_ch.item  = mem_r[rd_ptr_r];
  assign room2        = (cnt_r <= CNT_W'(DEPTH - 2));
  assign wr_ptr_1     = ptr_inc(wr_ptr_r);

  always_comb begin
    case (push_cnt)
      2'd1:    wr_ptr_nxt = wr_ptr_1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_data[0];
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_1] <= push_data[1];
    end
  end

endmodule

[hw/rtl/dma_burst_legalizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA burst legalizer core
// Cuts one-dimensional copy requests into read and write bursts that never
// cross a side's address boundary.
// ----------------------------------------------------------------------------
// in_ch carries load items (cmd = load) that start a transfer and advance
// items (cmd = advance) that, gated by read_ready and write_ready, release
// at most one read split and then one write split. out_ch carries the
// results in order, one per handshake: splits, zero-length rejects and
// busy refusals. The last result of an input item has run_end set.
// The cfg_ port writes the boundary and burst-mode registers; the user
// must write them only while idle, which the block does not enforce.
// An accepted item sits in an input register until the queue has room; its
// results enter the four-entry result queue at the edge that frees it. An
// item is accepted every cycle as long as the queue has room for two
// results; the single result port then sets the pace. A stalled receiver
// holds the queue head; once fewer than two entries are free, an item
// waits in the input register and in_ch.ready drops until the receiver
// drains it.
// Synchronous reset clears both sides, the queue and the input register
// and restores boundaries of 4 KiB with bursting on both sides.
// ----------------------------------------------------------------------------
module dma_burst_legalizer_core #(
  parameter int WIDTH_BYTES = dbl_pkg::WIDTH_BYTES_DEF,
  parameter int RES_DEPTH   = dbl_pkg::RES_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dbl_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [dbl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  dbl_in_if.sink                          in_ch,
  dbl_out_if.source                       out_ch
);

  localparam logic [6:0] WIDTH_V = 7'(WIDTH_BYTES);
  localparam logic [6:0] WMASK_V = 7'(WIDTH_BYTES - 1);

  // Configuration registers.
  logic [dbl_pkg::LG_W-1:0] rd_bnd_r, wr_bnd_r;
  logic                     rd_bursts_r, wr_bursts_r;

  // Input register.
  logic              in_v_r;
  dbl_pkg::in_item_t in_item_r;
  logic              room2;
  logic              fire;

  // Transfer state.
  logic                        rd_active_r, rd_active_nxt;
  logic [dbl_pkg::ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [dbl_pkg::LEN_W-1:0]   rd_left_r, rd_left_nxt;
  logic [dbl_pkg::LANE_W-1:0]  rd_shift_r, rd_shift_nxt;
  logic                        wr_active_r, wr_active_nxt;
  logic [dbl_pkg::ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic [dbl_pkg::LEN_W-1:0]   wr_left_r, wr_left_nxt;
  logic [dbl_pkg::LANE_W-1:0]  wr_shift_r, wr_shift_nxt;
  logic                        lockstep_r, lockstep_nxt;
  logic [1:0]                  flags_r, flags_nxt;

  logic [dbl_pkg::BYTES_W-1:0] rd_avail, wr_avail;
  logic [dbl_pkg::BYTES_W-1:0] rb, wb;
  logic                        rd_emit, wr_emit;
  logic [6:0]                  src_off, dst_off, dst_rot;
  dbl_pkg::out_item_t          rd_item, wr_item, rej_item;
  logic [1:0]                  push_cnt;
  dbl_pkg::out_item_t          push_data [2];

  assign fire        = in_v_r && room2;
  assign in_ch.ready = !in_v_r || room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_bnd_r    <= dbl_pkg::MAX_BND_LOG2;
      wr_bnd_r    <= dbl_pkg::MAX_BND_LOG2;
      rd_bursts_r <= 1'b1;
      wr_bursts_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (dbl_pkg::cfg_reg_t'(cfg_idx))
        dbl_pkg::REG_RD_BND_LOG2: rd_bnd_r    <= cfg_wdata;
        dbl_pkg::REG_WR_BND_LOG2: wr_bnd_r    <= cfg_wdata;
        dbl_pkg::REG_RD_BURSTS:   rd_bursts_r <= cfg_wdata[0];
        dbl_pkg::REG_WR_BURSTS:   wr_bursts_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_ch.item;
    end
  end

  dbl_side_len #(.WIDTH_BYTES(WIDTH_BYTES)) u_rd_len (
    .active    (rd_active_r),
    .next_addr (rd_addr_r),
    .left      (rd_left_r),
    .bnd_log2  (rd_bnd_r),
    .bursts    (rd_bursts_r),
    .avail     (rd_avail)
  );

  dbl_side_len #(.WIDTH_BYTES(WIDTH_BYTES)) u_wr_len (
    .active    (wr_active_r),
    .next_addr (wr_addr_r),
    .left      (wr_left_r),
    .bnd_log2  (wr_bnd_r),
    .bursts    (wr_bursts_r),
    .avail     (wr_avail)
  );

  // In lockstep both sides move the shorter burst and only when both are ready.
  always_comb begin
    if (lockstep_r) begin
      rb      = (rd_avail < wr_avail) ? rd_avail : wr_avail;
      wb      = rb;
      rd_emit = rd_active_r && in_item_r.read_ready && wr_active_r &&
                in_item_r.write_ready && (rb != '0);
      wr_emit = rd_emit;
    end else begin
      rb      = rd_avail;
      wb      = wr_avail;
      rd_emit = rd_active_r && in_item_r.read_ready && (rb != '0);
      wr_emit = wr_active_r && in_item_r.write_ready && (wb != '0);
    end
  end

  dbl_split_fmt #(.WIDTH_BYTES(WIDTH_BYTES)) u_rd_fmt (
    .kind  (dbl_pkg::KIND_READ),
    .addr  (rd_addr_r),
    .bytes (rb),
    .left  (rd_left_r),
    .shift (rd_shift_r),
    .flags (flags_r),
    .item  (rd_item)
  );

  dbl_split_fmt #(.WIDTH_BYTES(WIDTH_BYTES)) u_wr_fmt (
    .kind  (dbl_pkg::KIND_WRITE),
    .addr  (wr_addr_r),
    .bytes (wb),
    .left  (wr_left_r),
    .shift (wr_shift_r),
    .flags (flags_r),
    .item  (wr_item)
  );

  always_comb begin
    rd_active_nxt = rd_active_r;
    rd_addr_nxt   = rd_addr_r;
    rd_left_nxt   = rd_left_r;
    rd_shift_nxt  = rd_shift_r;
    wr_active_nxt = wr_active_r;
    wr_addr_nxt   = wr_addr_r;
    wr_left_nxt   = wr_left_r;
    wr_shift_nxt  = wr_shift_r;
    lockstep_nxt  = lockstep_r;
    flags_nxt     = flags_r;
    push_cnt      = 2'd0;
    push_data[0]  = rd_item;
    push_data[1]  = wr_item;

    src_off = in_item_r.src_addr[6:0] & WMASK_V;
    dst_off = in_item_r.dst_addr[6:0] & WMASK_V;
    dst_rot = (WIDTH_V - dst_off) & WMASK_V;

    rej_item         = '0;
    rej_item.kind    = (in_item_r.byte_count == '0) ? dbl_pkg::KIND_ZERO_LEN
                                                    : dbl_pkg::KIND_BUSY;
    rej_item.run_end = 1'b1;

    if (fire) begin
      if (in_item_r.cmd == dbl_pkg::CMD_LOAD) begin
        if ((in_item_r.byte_count == '0) || rd_active_r || wr_active_r) begin
          push_cnt     = 2'd1;
          push_data[0] = rej_item;
        end else begin
          rd_active_nxt = 1'b1;
          wr_active_nxt = 1'b1;
          rd_addr_nxt   = in_item_r.src_addr;
          wr_addr_nxt   = in_item_r.dst_addr;
          rd_left_nxt   = in_item_r.byte_count;
          wr_left_nxt   = in_item_r.byte_count;
          rd_shift_nxt  = src_off[dbl_pkg::LANE_W-1:0];
          wr_shift_nxt  = dst_rot[dbl_pkg::LANE_W-1:0];
          lockstep_nxt  = !in_item_r.indep_rw && rd_bursts_r && wr_bursts_r;
          flags_nxt     = {in_item_r.indep_aw, in_item_r.final_of_job};
        end
      end else begin
        if (rd_emit) begin
          rd_addr_nxt   = rd_addr_r + dbl_pkg::ADDR_W'(rb);
          rd_left_nxt   = rd_left_r - dbl_pkg::LEN_W'(rb);
          rd_active_nxt = (rd_left_nxt != '0);
        end
        if (wr_emit) begin
          wr_addr_nxt   = wr_addr_r + dbl_pkg::ADDR_W'(wb);
          wr_left_nxt   = wr_left_r - dbl_pkg::LEN_W'(wb);
          wr_active_nxt = (wr_left_nxt != '0);
        end
        // The read split goes first; the last result of the item closes the run.
        if (rd_emit && wr_emit) begin
          push_cnt             = 2'd2;
          push_data[1].run_end = 1'b1;
        end else if (rd_emit || wr_emit) begin
          push_cnt             = 2'd1;
          push_data[0]         = rd_emit ? rd_item : wr_item;
          push_data[0].run_end = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_active_r <= 1'b0;
      rd_addr_r   <= '0;
      rd_left_r   <= '0;
      rd_shift_r  <= '0;
      wr_active_r <= 1'b0;
      wr_addr_r   <= '0;
      wr_left_r   <= '0;
      wr_shift_r  <= '0;
      lockstep_r  <= 1'b0;
      flags_r     <= '0;
    end else begin
      rd_active_r <= rd_active_nxt;
      rd_addr_r   <= rd_addr_nxt;
      rd_left_r   <= rd_left_nxt;
      rd_shift_r  <= rd_shift_nxt;
      wr_active_r <= wr_active_nxt;
      wr_addr_r   <= wr_addr_nxt;
      wr_left_r   <= wr_left_nxt;
      wr_shift_r  <= wr_shift_nxt;
      lockstep_r  <= lockstep_nxt;
      flags_r     <= flags_nxt;
    end
  end

  dbl_result_fifo #(.DEPTH(RES_DEPTH)) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_data (push_data),
    .room2     (room2),
    .out_ch    (out_ch)
  );

endmodule

[hw/rtl/dbl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA burst legalizer checker
// Port-level assertions on the core's channels, bound to the top level.
// ----------------------------------------------------------------------------
module dbl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input dbl_pkg::out_item_t out_item
);

  // A result offered but not taken stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its payload.
  a_out_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("result item changed while stalled");

  // Reset empties the result path.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered right after reset");

  // From an empty output, a result appears only after an accepted input item.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result item appeared without an input item");

endmodule

bind dma_burst_legalizer_core dbl_checker u_dbl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.item)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA burst legalizer core testbench
// Drives load and advance items into the core, predicts every split, reject
// and refusal from a bit-accurate model of the splitter, and compares each
// result field by field under random idling on both channels and across
// several boundary and burst-mode register values.
// ----------------------------------------------------------------------------
module testbench;

  localparam int BUS_BYTES        = dbl_pkg::WIDTH_BYTES_DEF;
  localparam int BUS_LOG2         = $clog2(BUS_BYTES);
  localparam int ITEMS_PER_PLAN   = 188;

  typedef struct packed {
    logic [dbl_pkg::LG_W-1:0] rd_lg;
    logic [dbl_pkg::LG_W-1:0] wr_lg;
    logic                     rd_burst;
    logic                     wr_burst;
  } reg_plan_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [dbl_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [dbl_pkg::CFG_DATA_W-1:0] cfg_wdata;

  dbl_in_if  in_ch();
  dbl_out_if out_ch();

  dma_burst_legalizer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Register values visited by the random traffic, extremes included.
  reg_plan_t reg_plans [6] = '{
    '{4'd15, 4'd13, 1'b1, 1'b1},
    '{4'd0,  4'd0,  1'b1, 1'b1},
    '{4'd3,  4'd7,  1'b1, 1'b0},
    '{4'd9,  4'd2,  1'b0, 1'b1},
    '{4'd12, 4'd12, 1'b0, 1'b0},
    '{4'd5,  4'd12, 1'b1, 1'b1}
  };

  // Splitter model: registers and per-side transfer state.
  logic [dbl_pkg::LG_W-1:0]   rd_lg_cfg    = dbl_pkg::MAX_BND_LOG2;
  logic [dbl_pkg::LG_W-1:0]   wr_lg_cfg    = dbl_pkg::MAX_BND_LOG2;
  logic                       rd_burst_cfg = 1'b1;
  logic                       wr_burst_cfg = 1'b1;
  logic                       rd_busy      = 1'b0;
  logic                       wr_busy      = 1'b0;
  logic                       tied_sides   = 1'b0;
  logic [dbl_pkg::ADDR_W-1:0] rd_addr      = '0;
  logic [dbl_pkg::ADDR_W-1:0] wr_addr      = '0;
  logic [dbl_pkg::LEN_W-1:0]  rd_left      = '0;
  logic [dbl_pkg::LEN_W-1:0]  wr_left      = '0;
  logic [dbl_pkg::LANE_W-1:0] rd_shift     = '0;
  logic [dbl_pkg::LANE_W-1:0] wr_shift     = '0;
  logic [1:0]                 job_flags    = '0;

  dbl_pkg::out_item_t expected_splits [$];

  int src_idle_pct;
  int sink_idle_pct;
  int items_done;
  int transfers;
  int splits_predicted;
  int notices_predicted;
  int results_seen;
  int mismatches;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("dma_burst_legalizer_core: mismatch");
    $finish;
  end

  // Result receiver: random back-pressure at the current idle rate.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic logic [63:0] bytes_to_boundary(logic [dbl_pkg::ADDR_W-1:0] addr,
                                                    logic [dbl_pkg::LG_W-1:0] lg,
                                                    logic burst);
    logic [63:0] span;
    if (burst) begin
      span = 64'd1 << ((lg > dbl_pkg::MAX_BND_LOG2) ? dbl_pkg::MAX_BND_LOG2 : lg);
      return span - (addr & (span - 64'd1));
    end
    return 64'(BUS_BYTES) - (addr & 64'(BUS_BYTES - 1));
  endfunction

  function automatic dbl_pkg::out_item_t build_split(dbl_pkg::kind_t kind,
                                                     logic [dbl_pkg::ADDR_W-1:0] addr,
                                                     logic [63:0] nbytes,
                                                     logic [dbl_pkg::LEN_W-1:0] left,
                                                     logic [dbl_pkg::LANE_W-1:0] shift);
    dbl_pkg::out_item_t s;
    logic [63:0]        off;
    logic [63:0]        span_end;
    off             = addr & 64'(BUS_BYTES - 1);
    span_end        = nbytes + off - 64'd1;
    s               = '0;
    s.kind          = kind;
    s.split_addr    = addr;
    s.split_bytes   = nbytes[dbl_pkg::BYTES_W-1:0];
    s.first_offset  = off[dbl_pkg::LANE_W-1:0];
    s.tail_bytes    = dbl_pkg::LANE_W'((nbytes + off) & 64'(BUS_BYTES - 1));
    s.lane_shift    = shift;
    s.beat_count    = dbl_pkg::BEATS_W'((span_end >> BUS_LOG2) + 64'd1);
    s.last_split    = ({32'd0, left} == nbytes);
    s.job_last      = s.last_split && job_flags[0];
    s.aw_decoupled  = job_flags[1];
    s.run_end       = 1'b0;
    return s;
  endfunction

  // Updates the model for one accepted item and queues its results.
  function automatic int predict_item(dbl_pkg::in_item_t it);
    dbl_pkg::out_item_t rd_res, wr_res, note;
    logic [63:0]        rd_take, wr_take, room;
    logic               rd_go, wr_go, rd_fire, wr_fire;
    if (it.cmd == dbl_pkg::CMD_LOAD) begin
      if (it.byte_count == '0 || rd_busy || wr_busy) begin
        note         = '0;
        note.kind    = (it.byte_count == '0) ? dbl_pkg::KIND_ZERO_LEN : dbl_pkg::KIND_BUSY;
        note.run_end = 1'b1;
        expected_splits.push_back(note);
        notices_predicted++;
        return 1;
      end
      rd_busy    = 1'b1;
      wr_busy    = 1'b1;
      rd_addr    = it.src_addr;
      wr_addr    = it.dst_addr;
      rd_left    = it.byte_count;
      wr_left    = it.byte_count;
      rd_shift   = it.src_addr[dbl_pkg::LANE_W-1:0];
      wr_shift   = 3'd0 - it.dst_addr[dbl_pkg::LANE_W-1:0];
      tied_sides = !it.indep_rw && rd_burst_cfg && wr_burst_cfg;
      job_flags  = {it.indep_aw, it.final_of_job};
      transfers++;
      return 0;
    end
    rd_take = '0;
    wr_take = '0;
    if (rd_busy) begin
      room    = bytes_to_boundary(rd_addr, rd_lg_cfg, rd_burst_cfg);
      rd_take = ({32'd0, rd_left} < room) ? {32'd0, rd_left} : room;
    end
    if (wr_busy) begin
      room    = bytes_to_boundary(wr_addr, wr_lg_cfg, wr_burst_cfg);
      wr_take = ({32'd0, wr_left} < room) ? {32'd0, wr_left} : room;
    end
    rd_go = rd_busy && it.read_ready;
    wr_go = wr_busy && it.write_ready;
    // Coupled sides move the shorter burst and only when both are ready.
    if (tied_sides) begin
      if (wr_take < rd_take) rd_take = wr_take;
      wr_take = rd_take;
      rd_go   = rd_go && wr_go;
      wr_go   = rd_go;
    end
    rd_fire = rd_go && (rd_take != 0);
    wr_fire = wr_go && (wr_take != 0);
    if (rd_fire) begin
      rd_res  = build_split(dbl_pkg::KIND_READ, rd_addr, rd_take, rd_left, rd_shift);
      rd_addr = rd_addr + rd_take;
      rd_left = rd_left - rd_take[dbl_pkg::LEN_W-1:0];
      rd_busy = (rd_left != 0);
    end
    if (wr_fire) begin
      wr_res  = build_split(dbl_pkg::KIND_WRITE, wr_addr, wr_take, wr_left, wr_shift);
      wr_addr = wr_addr + wr_take;
      wr_left = wr_left - wr_take[dbl_pkg::LEN_W-1:0];
      wr_busy = (wr_left != 0);
    end
    if (wr_fire) wr_res.run_end = 1'b1;
    else if (rd_fire) rd_res.run_end = 1'b1;
    if (rd_fire) expected_splits.push_back(rd_res);
    if (wr_fire) expected_splits.push_back(wr_res);
    splits_predicted += int'(rd_fire) + int'(wr_fire);
    return int'(rd_fire) + int'(wr_fire);
  endfunction

  function automatic dbl_pkg::in_item_t make_load(logic [dbl_pkg::ADDR_W-1:0] src,
                                                  logic [dbl_pkg::ADDR_W-1:0] dst,
                                                  logic [dbl_pkg::LEN_W-1:0] len,
                                                  logic ind_rw, logic fin, logic ind_aw);
    dbl_pkg::in_item_t it;
    it              = '0;
    it.cmd          = dbl_pkg::CMD_LOAD;
    it.src_addr     = src;
    it.dst_addr     = dst;
    it.byte_count   = len;
    it.indep_rw     = ind_rw;
    it.final_of_job = fin;
    it.indep_aw     = ind_aw;
    return it;
  endfunction

  function automatic dbl_pkg::in_item_t make_advance(logic rd_rdy, logic wr_rdy);
    dbl_pkg::in_item_t it;
    it             = '0;
    it.cmd         = dbl_pkg::CMD_ADVANCE;
    it.read_ready  = rd_rdy;
    it.write_ready = wr_rdy;
    return it;
  endfunction

  // Every field random; callers override what the item is meant to be.
  function automatic dbl_pkg::in_item_t random_item();
    dbl_pkg::in_item_t it;
    it.cmd          = 1'($urandom_range(1));
    it.src_addr     = {$urandom, $urandom};
    it.dst_addr     = {$urandom, $urandom};
    it.byte_count   = $urandom;
    it.indep_rw     = 1'($urandom_range(1));
    it.final_of_job = 1'($urandom_range(1));
    it.indep_aw     = 1'($urandom_range(1));
    it.read_ready   = 1'($urandom_range(1));
    it.write_ready  = 1'($urandom_range(1));
    return it;
  endfunction

  // Keeps the number of splits per transfer modest for the current registers.
  function automatic int unsigned longest_transfer();
    int unsigned rd_e, wr_e, e;
    rd_e = rd_burst_cfg ? ((rd_lg_cfg > dbl_pkg::MAX_BND_LOG2) ? dbl_pkg::MAX_BND_LOG2
                                                               : rd_lg_cfg) : BUS_LOG2;
    wr_e = wr_burst_cfg ? ((wr_lg_cfg > dbl_pkg::MAX_BND_LOG2) ? dbl_pkg::MAX_BND_LOG2
                                                               : wr_lg_cfg) : BUS_LOG2;
    e    = (rd_e < wr_e) ? rd_e : wr_e;
    if (e < BUS_LOG2) return 48;
    return (e >= 9) ? 20000 : (64 << e);
  endfunction

  // Sends one item; valid stays high into the next call unless the sender idles.
  task automatic send_item(input dbl_pkg::in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk); while (!in_ch.ready);
    void'(predict_item(it));
    items_done++;
  endtask

  // Holds the sender until every queued result has come back.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (expected_splits.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input dbl_pkg::cfg_reg_t idx,
                                input logic [dbl_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      dbl_pkg::REG_RD_BND_LOG2: rd_lg_cfg    = val;
      dbl_pkg::REG_WR_BND_LOG2: wr_lg_cfg    = val;
      dbl_pkg::REG_RD_BURSTS:   rd_burst_cfg = val[0];
      dbl_pkg::REG_WR_BURSTS:   wr_burst_cfg = val[0];
      default: ;
    endcase
  endtask

  task automatic finish_transfer();
    while (rd_busy || wr_busy) send_item(make_advance(1'b1, 1'b1));
  endtask

  // Zero-length rejects, busy refusals and a coupled transfer across the
  // top of the address space.
  task automatic test_reject_and_refuse();
    send_item(make_load('1, '1, '0, 1'b1, 1'b1, 1'b1));
    send_item(make_advance(1'b1, 1'b1));
    send_item(make_load(64'hFFFF_FFFF_FFFF_FFFD, 64'h0000_0000_0000_0FFE, 32'd40,
                        1'b0, 1'b1, 1'b1));
    send_item(make_load(64'h1000, 64'h2000, '1, 1'b1, 1'b0, 1'b0));
    send_item(make_load('0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_item(make_advance(1'b1, 1'b0));
    send_item(make_advance(1'b0, 1'b0));
    finish_transfer();
  endtask

  // Independent sides, full 4 KiB bursts and a single-byte job end.
  task automatic test_decoupled_sides();
    send_item(make_load(64'h7, 64'h3, 32'd4101, 1'b1, 1'b0, 1'b0));
    send_item(make_advance(1'b1, 1'b0));
    send_item(make_advance(1'b0, 1'b1));
    finish_transfer();
    send_item(make_load(64'h0, 64'h1000, 32'd8192, 1'b0, 1'b0, 1'b1));
    finish_transfer();
    send_item(make_load(64'h0000_0000_0000_FFF8, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1,
                        1'b1, 1'b1, 1'b1));
    finish_transfer();
  endtask

  // One load followed by advances until both sides are done, with busy
  // loads and zero-length loads mixed in as noise.
  task automatic run_transfer();
    dbl_pkg::in_item_t it;
    int unsigned       pick;
    if ($urandom_range(9) == 0) begin
      it     = random_item();
      it.cmd = ($urandom_range(1) == 0) ? dbl_pkg::CMD_ADVANCE : dbl_pkg::CMD_LOAD;
      it.byte_count = '0;
      send_item(it);
    end
    it     = random_item();
    it.cmd = dbl_pkg::CMD_LOAD;
    it.byte_count = ($urandom_range(3) == 0) ? $urandom_range(longest_transfer(), 1)
                                             : $urandom_range(40, 1);
    if ($urandom_range(7) == 0) it.src_addr = ~64'($urandom_range(300));
    if ($urandom_range(7) == 0) it.dst_addr = ~64'($urandom_range(300));
    send_item(it);
    while (rd_busy || wr_busy) begin
      it   = random_item();
      pick = $urandom_range(99);
      if (pick < 5) begin
        it.cmd = dbl_pkg::CMD_LOAD;
      end else if (pick < 8) begin
        it.cmd        = dbl_pkg::CMD_LOAD;
        it.byte_count = '0;
      end else begin
        it.cmd         = dbl_pkg::CMD_ADVANCE;
        it.read_ready  = ($urandom_range(99) < 70);
        it.write_ready = ($urandom_range(99) < 70);
      end
      send_item(it);
    end
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                     input int first_plan);
    for (int p = first_plan; p < first_plan + 2; p++) begin
      int stop_at;
      wait_for_drain();
      src_idle_pct  = src_pct;
      sink_idle_pct = snk_pct;
      write_register(dbl_pkg::REG_RD_BND_LOG2, reg_plans[p].rd_lg);
      write_register(dbl_pkg::REG_WR_BND_LOG2, reg_plans[p].wr_lg);
      write_register(dbl_pkg::REG_RD_BURSTS,   {3'd0, reg_plans[p].rd_burst});
      write_register(dbl_pkg::REG_WR_BURSTS,   {3'd0, reg_plans[p].wr_burst});
      cfg_we  <= 1'b0;
      stop_at = items_done + ITEMS_PER_PLAN;
      while (items_done < stop_at) begin
        run_transfer();
        if ($urandom_range(19) == 0) wait_for_drain();
      end
    end
  endtask

  function automatic bit field_differs(string name, logic [63:0] got, logic [63:0] want);
    if (got === want) return 1'b0;
    if (mismatches < 10)
      $display("result %0d %s: expected %0h, got %0h", results_seen, name, want, got);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    dbl_pkg::out_item_t want, got;
    bit                 bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.item;
      results_seen++;
      if (expected_splits.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d arrived with nothing expected: %h", results_seen, got);
        mismatches++;
      end else begin
        want = expected_splits.pop_front();
        bad = field_differs("kind",         64'(got.kind),         64'(want.kind))
            | field_differs("split_addr",   got.split_addr,        want.split_addr)
            | field_differs("split_bytes",  64'(got.split_bytes),  64'(want.split_bytes))
            | field_differs("first_offset", 64'(got.first_offset), 64'(want.first_offset))
            | field_differs("tail_bytes",   64'(got.tail_bytes),   64'(want.tail_bytes))
            | field_differs("lane_shift",   64'(got.lane_shift),   64'(want.lane_shift))
            | field_differs("beat_count",   64'(got.beat_count),   64'(want.beat_count))
            | field_differs("last_split",   64'(got.last_split),   64'(want.last_split))
            | field_differs("job_last",     64'(got.job_last),     64'(want.job_last))
            | field_differs("aw_decoupled", 64'(got.aw_decoupled), 64'(want.aw_decoupled))
            | field_differs("run_end",      64'(got.run_end),      64'(want.run_end));
        if (bad) mismatches++;
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.item    <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= dbl_pkg::REG_RD_BND_LOG2;
    cfg_wdata     <= '0;
    src_idle_pct  = 14;
    sink_idle_pct = 85;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reject_and_refuse();
    test_decoupled_sides();
    test_random_traffic(14, 85, 0);
    test_random_traffic(85, 14, 2);
    test_random_traffic(0, 0, 4);

    wait_for_drain();
    repeat (16) @(posedge clk);
    $display("Sent %0d items: %0d transfers, %0d splits, %0d rejects and refusals expected",
             items_done, transfers, splits_predicted, notices_predicted);
    $display("Checked %0d results over six register plans, %0d of them wrong",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("dma_burst_legalizer_core: match");
    end else begin
      $display("dma_burst_legalizer_core: mismatch");
    end
    $finish;
  end

endmodule
